### sv/ftac_pkg.sv
// ============================================================================
// Flow table accounting package
// Shared constants, controller states and the command/status bundles.
// ============================================================================
package ftac_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = 10;
    localparam int CNT_W         = 11;
    localparam int KEY_W         = 97;
    localparam int DATA_W        = 144;

    localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DATA_RD,
        ST_MISS,
        ST_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_key;
        logic scan_clr;
        logic scan_inc;
        logic key_rd;
        logic data_rd;
        logic key_wr;
        logic take_new;
        logic take_hit;
        logic emit_update;
        logic emit_drop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;
        logic last;
        logic empty;
        logic full;
        logic out_free;
    } status_t;

endpackage

### sv/ftac_if.sv
// ============================================================================
// Flow table accounting channels
// Valid/ready interfaces for packet headers and per-packet results.
// ============================================================================
interface ftac_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        is_tcp;
    logic [15:0] packet_length;
    logic [31:0] timestamp;

    modport source (output valid, source_address, dest_address, source_port,
                    dest_port, is_tcp, packet_length, timestamp, input ready);
    modport sink (input valid, source_address, dest_address, source_port,
                  dest_port, is_tcp, packet_length, timestamp, output ready);
endinterface

interface ftac_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  flow_slot;
    logic        new_flow;
    logic        dropped;
    logic [31:0] flow_packets;
    logic [47:0] flow_bytes;
    logic [31:0] flow_first_seen;
    logic [10:0] active_flows;

    modport source (output valid, flow_slot, new_flow, dropped, flow_packets,
                    flow_bytes, flow_first_seen, active_flows, input ready);
    modport sink (input valid, flow_slot, new_flow, dropped, flow_packets,
                  flow_bytes, flow_first_seen, active_flows, output ready);
endinterface

### sv/ftac_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module ftac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/ftac_ctrl.sv
// ============================================================================
// Flow table controller
// Sequences the linear key scan, the insert and the counter update.
// ============================================================================
module ftac_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ftac_pkg::status_t status,
    output ftac_pkg::cmd_t    cmd
);

    ftac_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftac_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftac_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ftac_pkg::ST_READ;
                end
            end
            ftac_pkg::ST_READ:
            begin
                if (status.empty)
                begin
                    state_next = ftac_pkg::ST_MISS;
                end
                else
                begin
                    state_next = ftac_pkg::ST_CMP;
                end
            end
            ftac_pkg::ST_CMP:
            begin
                priority if (status.match)
                begin
                    state_next = ftac_pkg::ST_DATA_RD;
                end
                else if (status.last)
                begin
                    state_next = ftac_pkg::ST_MISS;
                end
                else
                begin
                    state_next = ftac_pkg::ST_READ;
                end
            end
            ftac_pkg::ST_DATA_RD:
            begin
                state_next = ftac_pkg::ST_UPDATE;
            end
            ftac_pkg::ST_MISS:
            begin
                priority if (!status.full)
                begin
                    state_next = ftac_pkg::ST_UPDATE;
                end
                else if (status.out_free)
                begin
                    state_next = ftac_pkg::ST_IDLE;
                end
            end
            ftac_pkg::ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ftac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftac_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ftac_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_key = in_valid;
                cmd.scan_clr = in_valid;
            end
            ftac_pkg::ST_READ:
            begin
                cmd.key_rd = 1'b1;
            end
            ftac_pkg::ST_CMP:
            begin
                cmd.take_hit = status.match;
                cmd.data_rd  = status.match;
                cmd.scan_inc = !status.match && !status.last;
            end
            ftac_pkg::ST_DATA_RD:
            begin
                cmd = '0;
            end
            ftac_pkg::ST_MISS:
            begin
                cmd.key_wr    = !status.full;
                cmd.take_new  = !status.full;
                cmd.emit_drop = status.full && status.out_free;
            end
            ftac_pkg::ST_UPDATE:
            begin
                cmd.emit_update = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### sv/ftac_dp.sv
// ============================================================================
// Flow table datapath
// Key and counter memories, scan index, flow count and the result register.
// ============================================================================
module ftac_dp (
    input  logic              clk,
    input  logic              rst_n,
    ftac_pkt_if.sink          packet,
    ftac_res_if.source        result,
    input  ftac_pkg::cmd_t    cmd,
    output ftac_pkg::status_t status
);

    logic [ftac_pkg::KEY_W-1:0]  key_reg;
    logic [15:0]                 len_reg;
    logic [31:0]                 ts_reg;
    logic [ftac_pkg::IDX_W-1:0]  scan_reg;
    logic [ftac_pkg::IDX_W-1:0]  slot_reg;
    logic                        new_reg;
    logic [ftac_pkg::CNT_W-1:0]  count_reg;
    logic                        out_valid_reg;

    logic [ftac_pkg::KEY_W-1:0]  key_rd_data;
    logic [ftac_pkg::DATA_W-1:0] data_rd_data;
    logic [ftac_pkg::DATA_W-1:0] data_wr;
    logic [31:0]                 old_pkts, new_pkts, old_first;
    logic [47:0]                 old_bytes, new_bytes;
    logic [48:0]                 byte_sum;
    logic [ftac_pkg::CNT_W-1:0]  count_after;

    ftac_ram #(.WIDTH(ftac_pkg::KEY_W), .DEPTH(ftac_pkg::TABLE_ENTRIES)) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.key_wr),
        .wr_addr (count_reg[ftac_pkg::IDX_W-1:0]),
        .wr_data (key_reg),
        .rd_en   (cmd.key_rd),
        .rd_addr (scan_reg),
        .rd_data (key_rd_data)
    );

    ftac_ram #(.WIDTH(ftac_pkg::DATA_W), .DEPTH(ftac_pkg::TABLE_ENTRIES)) u_data_ram (
        .clk     (clk),
        .wr_en   (cmd.emit_update),
        .wr_addr (slot_reg),
        .wr_data (data_wr),
        .rd_en   (cmd.data_rd),
        .rd_addr (scan_reg),
        .rd_data (data_rd_data)
    );

    // Status toward the controller.
    assign status.match    = (key_rd_data == key_reg);
    assign status.last     = ({1'b0, scan_reg} + ftac_pkg::CNT_W'(1)) == count_reg;
    assign status.empty    = (count_reg == '0);
    assign status.full     = (count_reg == ftac_pkg::COUNT_FULL);
    assign status.out_free = !out_valid_reg || result.ready;

    // Saturating counter update; a new entry starts from zero.
    always_comb
    begin
        if (new_reg)
        begin
            old_pkts  = '0;
            old_bytes = '0;
            old_first = ts_reg;
        end
        else
        begin
            old_pkts  = data_rd_data[31:0];
            old_bytes = data_rd_data[79:32];
            old_first = data_rd_data[111:80];
        end
        new_pkts  = (old_pkts == ftac_pkg::PKT_MAX) ? old_pkts : old_pkts + 32'd1;
        byte_sum  = {1'b0, old_bytes} + {33'd0, len_reg};
        new_bytes = byte_sum[48] ? ftac_pkg::BYTE_MAX : byte_sum[47:0];
        data_wr   = {ts_reg, old_first, new_bytes, new_pkts};
        count_after = new_reg ? count_reg + ftac_pkg::CNT_W'(1) : count_reg;
    end

    // Captured packet.
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= {packet.source_address, packet.dest_address,
                        packet.source_port, packet.dest_port, packet.is_tcp};
            len_reg <= packet.packet_length;
            ts_reg  <= packet.timestamp;
        end
    end

    // Scan index, chosen slot and flow count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            slot_reg  <= '0;
            new_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
                new_reg  <= 1'b0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + ftac_pkg::IDX_W'(1);
            end
            if (cmd.take_hit)
            begin
                slot_reg <= scan_reg;
            end
            else if (cmd.take_new)
            begin
                slot_reg <= count_reg[ftac_pkg::IDX_W-1:0];
                new_reg  <= 1'b1;
            end
            if (cmd.emit_update)
            begin
                count_reg <= count_after;
            end
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_update || cmd.emit_drop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_update)
        begin
            result.flow_slot       <= slot_reg;
            result.new_flow        <= new_reg;
            result.dropped         <= 1'b0;
            result.flow_packets    <= new_pkts;
            result.flow_bytes      <= new_bytes;
            result.flow_first_seen <= old_first;
            result.active_flows    <= count_after;
        end
        else if (cmd.emit_drop)
        begin
            result.flow_slot       <= '0;
            result.new_flow        <= 1'b0;
            result.dropped         <= 1'b1;
            result.flow_packets    <= '0;
            result.flow_bytes      <= '0;
            result.flow_first_seen <= '0;
            result.active_flows    <= count_reg;
        end
    end

    assign result.valid = out_valid_reg;

endmodule

### sv/flow_table_accounting_top.sv
// ============================================================================
// Flow table accounting
// Five-tuple exact-match flow table with saturating per-flow counters.
// ============================================================================
// The packet channel takes one header per transfer; the result channel gives
// exactly one result per header, in order. A header is looked up by a linear
// scan of the key memory over the occupied slots, each slot being read and
// then compared. Flows are never removed, so occupied slots are always
// slots 0 to count-1 and a new flow takes slot count.
// The next header is taken in the cycle after the result is loaded, so
// throughput is set by the key scan.
// The result register parts the two sides: a new header is taken while a
// result waits, and the block only holds in its final step if the receiver
// still stalls the previous result.
// Reset clears the flow count and the control state; memories need no clear.
// A full table drops the packet and reports it with the dropped flag.
// ============================================================================
module flow_table_accounting_top (
    input  logic       clk,
    input  logic       rst_n,
    ftac_pkt_if.sink   packet,
    ftac_res_if.source result
);

    ftac_pkg::cmd_t    cmd;
    ftac_pkg::status_t status;

    ftac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (packet.valid),
        .in_ready (packet.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ftac_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule
